FILE: hdl/matrix_cell_table_engine_defines.svh
// Assertion macros for the matrix cell table engine.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MATRIX_CELL_TABLE_ENGINE_DEFINES_SVH
`define MATRIX_CELL_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, muted during reset.
`define MCTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted during reset.
`define MCTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mcte_pkg.sv
// Shared types and constants for the matrix cell table engine.
// No dependencies; used by the accumulator unit and the top level.
package mcte_pkg;

    localparam int ROWS_DEF = 16;
    localparam int COLS_DEF = 16;

    localparam int CELL_W  = 32;
    localparam int SUM_W   = 40;
    localparam int CNT_W   = 9;
    localparam int COORD_W = 5;
    localparam int KIND_W  = 4;

    // -999 marks an empty cell
    localparam logic signed [CELL_W-1:0] EMPTY_CELL = -32'sd999;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 4'd0,
        KIND_EDIT   = 4'd1,
        KIND_DELETE = 4'd2,
        KIND_SEARCH = 4'd3,
        KIND_COUNT  = 4'd4,
        KIND_SUM    = 4'd5,
        KIND_MAX    = 4'd6,
        KIND_MIN    = 4'd7,
        KIND_CLEAR  = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [COORD_W-1:0]       cell_row;
        logic [COORD_W-1:0]       cell_col;
        logic signed [CELL_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic                     status;
        logic                     found;
        logic [COORD_W-1:0]       found_row;
        logic [COORD_W-1:0]       found_col;
        logic [CNT_W-1:0]         match_count;
        logic signed [SUM_W-1:0]  total;
        logic signed [CELL_W-1:0] extreme_value;
        logic [COORD_W-1:0]       used_rows;
        logic [COORD_W-1:0]       used_cols;
    } result_t;

    // Controller to accumulator unit
    typedef struct packed {
        logic              start;  // clear all accumulators
        logic              eval;   // read data valid this cycle
        logic [KIND_W-1:0] kind;
    } acc_ctl_t;

endpackage

FILE: hdl/mcte_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mcte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/mcte_acc.sv
// Accumulator unit: folds one cell per cycle, while eval is set, into search,
// count, sum, extreme and delete-bound results. Depends on mcte_pkg.
module mcte_acc #(
    parameter int ROWS = mcte_pkg::ROWS_DEF,
    parameter int COLS = mcte_pkg::COLS_DEF,
    localparam int RW  = $clog2(ROWS + 1),
    localparam int CW  = $clog2(COLS + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mcte_pkg::acc_ctl_t                ctl,
    input  logic signed [mcte_pkg::CELL_W-1:0] cell_data,
    input  logic [RW-1:0]                     row,
    input  logic [CW-1:0]                     col,
    input  logic signed [mcte_pkg::CELL_W-1:0] value,
    output logic                              found,
    output logic [RW-1:0]                     found_row,
    output logic [CW-1:0]                     found_col,
    output logic [mcte_pkg::CNT_W-1:0]        match_count,
    output logic signed [mcte_pkg::SUM_W-1:0] total,
    output logic signed [mcte_pkg::CELL_W-1:0] extreme,
    output logic [RW-1:0]                     del_row,
    output logic [CW-1:0]                     del_col,
    output logic                              del_wr
);

    localparam int EXT = mcte_pkg::SUM_W - mcte_pkg::CELL_W;

    logic filled;
    logic hit;
    logic better;

    assign filled = (cell_data != mcte_pkg::EMPTY_CELL);
    assign hit    = (cell_data == value);
    assign better = (ctl.kind == mcte_pkg::KIND_MAX) ? (cell_data > extreme)
                                                      : (cell_data < extreme);
    assign del_wr = ctl.eval && (ctl.kind == mcte_pkg::KIND_DELETE) && filled && hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found       <= 1'b0;
            found_row   <= '0;
            found_col   <= '0;
            match_count <= '0;
            total       <= '0;
            extreme     <= '0;
            del_row     <= '0;
            del_col     <= '0;
        end
        else if (ctl.start)
        begin
            found       <= 1'b0;
            found_row   <= '0;
            found_col   <= '0;
            match_count <= '0;
            total       <= '0;
            extreme     <= '0;
            del_row     <= '0;
            del_col     <= '0;
        end
        else if (ctl.eval)
        begin
            case (ctl.kind)
                mcte_pkg::KIND_SEARCH:
                begin
                    if (hit && !found)
                    begin
                        found     <= 1'b1;
                        found_row <= row;
                        found_col <= col;
                    end
                end
                mcte_pkg::KIND_COUNT:
                begin
                    if (hit)
                    begin
                        match_count <= match_count + 1'b1;
                    end
                end
                mcte_pkg::KIND_SUM:
                begin
                    if (filled)
                    begin
                        total <= total + {{EXT{cell_data[mcte_pkg::CELL_W-1]}}, cell_data};
                    end
                end
                mcte_pkg::KIND_MAX, mcte_pkg::KIND_MIN:
                begin
                    if (filled && (!found || better))
                    begin
                        found   <= 1'b1;
                        extreme <= cell_data;
                    end
                end
                mcte_pkg::KIND_DELETE:
                begin
                    // rows come in ascending order; columns need a compare
                    if (filled && !hit)
                    begin
                        del_row <= row;
                        if (col > del_col)
                        begin
                            del_col <= col;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: hdl/matrix_cell_table_engine.sv
// Top level of the matrix cell table engine: sequencer, address walk and
// bounds. Depends on mcte_pkg, mcte_ram, mcte_acc and the defines header.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-------------------------
//   item     | in        | item_valid / item_stall    | mcte_pkg::item_t
//   result   | out       | result_valid / result_stall| mcte_pkg::result_t
//
// One item at a time. Add and edit pass decode, write and done (refused ones skip
// the write); delete walks all ROWS*COLS cells; search, count, sum, max and min
// walk the row_bound*col_bound window (skipped when the bounds are empty); clear
// rewrites all ROWS*COLS cells; unknown kinds go from decode to done. The walk is
// set by the single read port of the cell memory: one cell a cycle.
// After reset a clearing pass writes -999 to all ROWS*COLS cells, one per
// cycle; item_stall stays high during it.
// A finished result sits in the output register; the next item is taken
// while it waits, and the engine holds only if a second result is ready first.
`include "matrix_cell_table_engine_defines.svh"

module matrix_cell_table_engine #(
    parameter int ROWS = mcte_pkg::ROWS_DEF,
    parameter int COLS = mcte_pkg::COLS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mcte_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output mcte_pkg::result_t result
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = $clog2(ROWS + 1);
    localparam int CW    = $clog2(COLS + 1);
    localparam int CELLW = mcte_pkg::CELL_W;

    mcte_pkg::state_t   state_reg, state_next;
    mcte_pkg::item_t    item_reg;
    mcte_pkg::acc_ctl_t acc_ctl;
    mcte_pkg::result_t  result_reg, result_next;
    logic               result_valid_reg;

    logic              status_reg;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [RW-1:0]     row_bound_reg, col_bound_unused;
    logic [CW-1:0]     col_bound_reg;

    // scan walk
    logic [RW-1:0]     row_reg, row_lim_reg;
    logic [CW-1:0]     col_reg, col_lim_reg;
    logic [AW-1:0]     addr_reg, base_reg;
    // read in flight, evaluated in the cycle after it is issued
    logic              pend_reg;
    logic [RW-1:0]     pend_row_reg;
    logic [CW-1:0]     pend_col_reg;
    logic [AW-1:0]     pend_addr_reg;

    // memory ports
    logic                    ram_wr_en;
    logic [AW-1:0]           ram_wr_addr;
    logic [CELLW-1:0]        ram_wr_data;
    logic                    ram_rd_en;
    logic [AW-1:0]           ram_rd_addr;
    logic signed [CELLW-1:0] ram_rd_data;

    // accumulator results
    logic                                acc_found;
    logic [RW-1:0]                       acc_frow;
    logic [CW-1:0]                       acc_fcol;
    logic [mcte_pkg::CNT_W-1:0]          acc_cnt;
    logic signed [mcte_pkg::SUM_W-1:0]   acc_total;
    logic signed [CELLW-1:0]             acc_ext;
    logic [RW-1:0]                       acc_del_row;
    logic [CW-1:0]                       acc_del_col;
    logic                                acc_del_wr;

    // decode helpers
    logic [mcte_pkg::COORD_W-1:0] row_m1, col_m1;
    logic [AW-1:0]     cell_addr;
    logic              in_range;
    logic              store_full;
    logic              is_wr_kind;
    logic              is_scan_kind;
    logic              refuse;
    logic              bounds_empty;
    logic              add_ok;
    logic              clr_last;
    logic              scan_last;
    logic              out_free;
    logic              accept;
    logic [RW-1:0]     rows_after;
    logic [CW-1:0]     cols_after;

    assign col_bound_unused = '0;

    assign row_m1    = item_reg.cell_row - 5'd1;
    assign col_m1    = item_reg.cell_col - 5'd1;
    assign cell_addr = AW'(int'(row_m1) * COLS + int'(col_m1));
    assign in_range  = (item_reg.cell_row != '0) && (int'(item_reg.cell_row) <= ROWS) &&
                       (item_reg.cell_col != '0) && (int'(item_reg.cell_col) <= COLS);
    assign store_full = (row_bound_reg == RW'(ROWS)) && (col_bound_reg == CW'(COLS));

    assign is_wr_kind   = item_reg.kind inside {mcte_pkg::KIND_ADD, mcte_pkg::KIND_EDIT};
    assign is_scan_kind = item_reg.kind inside {mcte_pkg::KIND_SEARCH, mcte_pkg::KIND_COUNT,
                                                mcte_pkg::KIND_SUM, mcte_pkg::KIND_MAX,
                                                mcte_pkg::KIND_MIN};
    assign refuse       = store_full || !in_range;
    assign bounds_empty = (row_bound_reg == '0) || (col_bound_reg == '0);
    // add only lands in an empty cell; edit always lands
    assign add_ok       = (item_reg.kind == mcte_pkg::KIND_EDIT) ||
                          (ram_rd_data == mcte_pkg::EMPTY_CELL);

    assign clr_last  = (clr_cnt_reg == AW'(DEPTH - 1));
    assign scan_last = (row_reg == row_lim_reg) && (col_reg == col_lim_reg);
    assign out_free  = !result_valid_reg || !result_stall;
    assign accept    = item_valid && !item_stall;

    // delete rebuilds the bounds; every other kind leaves them as they stand
    assign rows_after = (item_reg.kind == mcte_pkg::KIND_DELETE) ? acc_del_row : row_bound_reg;
    assign cols_after = (item_reg.kind == mcte_pkg::KIND_DELETE) ? acc_del_col : col_bound_reg;

    assign clr_cnt_next = clr_last ? '0 : clr_cnt_reg + 1'b1;

    //--------------------------------------------------------------------
    // Next state
    //--------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mcte_pkg::ST_INIT:
            begin
                if (clr_last)
                begin
                    state_next = mcte_pkg::ST_IDLE;
                end
            end
            mcte_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = mcte_pkg::ST_DECODE;
                end
            end
            mcte_pkg::ST_DECODE:
            begin
                if (is_wr_kind)
                begin
                    state_next = refuse ? mcte_pkg::ST_DONE : mcte_pkg::ST_WRITE;
                end
                else if (item_reg.kind == mcte_pkg::KIND_DELETE)
                begin
                    state_next = mcte_pkg::ST_SCAN;
                end
                else if (is_scan_kind)
                begin
                    state_next = bounds_empty ? mcte_pkg::ST_DONE : mcte_pkg::ST_SCAN;
                end
                else if (item_reg.kind == mcte_pkg::KIND_CLEAR)
                begin
                    state_next = mcte_pkg::ST_CLEAR;
                end
                else
                begin
                    state_next = mcte_pkg::ST_DONE;
                end
            end
            mcte_pkg::ST_WRITE:
            begin
                state_next = mcte_pkg::ST_DONE;
            end
            mcte_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = mcte_pkg::ST_DRAIN;
                end
            end
            mcte_pkg::ST_DRAIN:
            begin
                state_next = mcte_pkg::ST_DONE;
            end
            mcte_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = mcte_pkg::ST_DONE;
                end
            end
            mcte_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = mcte_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mcte_pkg::ST_IDLE;
            end
        endcase
    end

    //--------------------------------------------------------------------
    // Control outputs
    //--------------------------------------------------------------------
    always_comb
    begin
        item_stall    = (state_reg != mcte_pkg::ST_IDLE);
        ram_rd_en     = 1'b0;
        ram_rd_addr   = addr_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = pend_addr_reg;
        ram_wr_data   = mcte_pkg::EMPTY_CELL;
        acc_ctl.start = 1'b0;
        acc_ctl.eval  = pend_reg;
        acc_ctl.kind  = item_reg.kind;
        case (state_reg)
            mcte_pkg::ST_INIT, mcte_pkg::ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_cnt_reg;
            end
            mcte_pkg::ST_DECODE:
            begin
                acc_ctl.start = 1'b1;
                ram_rd_en     = is_wr_kind && !refuse;
                ram_rd_addr   = cell_addr;
            end
            mcte_pkg::ST_WRITE:
            begin
                ram_wr_en   = add_ok;
                ram_wr_addr = cell_addr;
                ram_wr_data = item_reg.value;
            end
            mcte_pkg::ST_SCAN:
            begin
                ram_rd_en = 1'b1;
                ram_wr_en = acc_del_wr;
            end
            mcte_pkg::ST_DRAIN:
            begin
                ram_wr_en = acc_del_wr;
            end
            default:
            begin
            end
        endcase
    end

    //--------------------------------------------------------------------
    // Result assembly; fields a kind does not produce stay zero
    //--------------------------------------------------------------------
    always_comb
    begin
        result_next           = '0;
        result_next.status    = status_reg;
        result_next.used_rows = mcte_pkg::COORD_W'(rows_after);
        result_next.used_cols = mcte_pkg::COORD_W'(cols_after);
        case (item_reg.kind)
            mcte_pkg::KIND_SEARCH:
            begin
                result_next.found     = acc_found;
                result_next.found_row = mcte_pkg::COORD_W'(acc_frow);
                result_next.found_col = mcte_pkg::COORD_W'(acc_fcol);
            end
            mcte_pkg::KIND_COUNT:
            begin
                result_next.match_count = acc_cnt;
            end
            mcte_pkg::KIND_SUM:
            begin
                result_next.total = acc_total;
            end
            mcte_pkg::KIND_MAX, mcte_pkg::KIND_MIN:
            begin
                result_next.found         = acc_found;
                result_next.extreme_value = acc_ext;
            end
            default:
            begin
            end
        endcase
    end

    //--------------------------------------------------------------------
    // Registers
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mcte_pkg::ST_INIT;
            result_valid_reg <= 1'b0;
            clr_cnt_reg      <= '0;
            row_bound_reg    <= '0;
            col_bound_reg    <= '0;
            pend_reg         <= 1'b0;
            status_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == mcte_pkg::ST_SCAN);

            if ((state_reg == mcte_pkg::ST_INIT) || (state_reg == mcte_pkg::ST_CLEAR))
            begin
                clr_cnt_reg <= clr_cnt_next;
            end

            if (state_reg == mcte_pkg::ST_DECODE)
            begin
                status_reg <= is_wr_kind && refuse;
            end

            if ((state_reg == mcte_pkg::ST_WRITE) && (item_reg.kind == mcte_pkg::KIND_ADD))
            begin
                status_reg <= !add_ok;
                if (add_ok)
                begin
                    if (row_bound_reg < RW'(item_reg.cell_row))
                    begin
                        row_bound_reg <= RW'(item_reg.cell_row);
                    end
                    if (col_bound_reg < CW'(item_reg.cell_col))
                    begin
                        col_bound_reg <= CW'(item_reg.cell_col);
                    end
                end
            end

            if ((state_reg == mcte_pkg::ST_CLEAR) && clr_last)
            begin
                row_bound_reg <= col_bound_unused;
                col_bound_reg <= '0;
            end

            // result register: load when the slot frees, else drain on transfer
            if ((state_reg == mcte_pkg::ST_DONE) && out_free)
            begin
                result_valid_reg <= 1'b1;
                row_bound_reg    <= rows_after;
                col_bound_reg    <= cols_after;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload and walk registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end

        if ((state_reg == mcte_pkg::ST_DONE) && out_free)
        begin
            result_reg <= result_next;
        end

        if (state_reg == mcte_pkg::ST_DECODE)
        begin
            row_reg  <= RW'(1);
            col_reg  <= CW'(1);
            addr_reg <= '0;
            base_reg <= '0;
            if (item_reg.kind == mcte_pkg::KIND_DELETE)
            begin
                row_lim_reg <= RW'(ROWS);
                col_lim_reg <= CW'(COLS);
            end
            else
            begin
                row_lim_reg <= row_bound_reg;
                col_lim_reg <= col_bound_reg;
            end
        end
        else if (state_reg == mcte_pkg::ST_SCAN)
        begin
            // row-major walk over the active window
            if (col_reg == col_lim_reg)
            begin
                row_reg  <= row_reg + 1'b1;
                col_reg  <= CW'(1);
                base_reg <= base_reg + AW'(COLS);
                addr_reg <= base_reg + AW'(COLS);
            end
            else
            begin
                col_reg  <= col_reg + 1'b1;
                addr_reg <= addr_reg + 1'b1;
            end
        end

        pend_row_reg  <= row_reg;
        pend_col_reg  <= col_reg;
        pend_addr_reg <= addr_reg;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    //--------------------------------------------------------------------
    // Units
    //--------------------------------------------------------------------
    mcte_ram #(
        .WIDTH (CELLW),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    mcte_acc #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (acc_ctl),
        .cell_data   (ram_rd_data),
        .row         (pend_row_reg),
        .col         (pend_col_reg),
        .value       (item_reg.value),
        .found       (acc_found),
        .found_row   (acc_frow),
        .found_col   (acc_fcol),
        .match_count (acc_cnt),
        .total       (acc_total),
        .extreme     (acc_ext),
        .del_row     (acc_del_row),
        .del_col     (acc_del_col),
        .del_wr      (acc_del_wr)
    );

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------
    // bounds never leave the table
    `MCTE_ASSERT_NOW(a_bounds_in_table, 1'b1,
        (int'(row_bound_reg) <= ROWS) && (int'(col_bound_reg) <= COLS),
        "bounds outside the table")
    // a new result only appears out of the done state
    `MCTE_ASSERT_NEXT(a_result_from_done, !result_valid_reg,
        !result_valid_reg || ($past(state_reg) == mcte_pkg::ST_DONE),
        "result loaded outside done state")
    // write-back during the walk is only ever a delete of a read in flight
    `MCTE_ASSERT_NOW(a_walk_write_is_delete,
        ram_wr_en && ((state_reg == mcte_pkg::ST_SCAN) || (state_reg == mcte_pkg::ST_DRAIN)),
        pend_reg && (item_reg.kind == mcte_pkg::KIND_DELETE),
        "unexpected memory write during walk")

endmodule
